>>> rtl/ecgepi_pkg.sv
// ----------------------------------------------------------------------------
// ecgepi_pkg
// shared types, constants and the microcode table of the ecg envelope and
// peak interval block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecgepi_pkg;

    // record length and index widths
    localparam int RECORD_LEN = 4096;
    localparam int POS_W      = $clog2(RECORD_LEN);
    localparam int IDX_W      = 12;
    localparam int CNT_W      = (POS_W > IDX_W) ? POS_W : IDX_W;

    // peak count saturates here
    localparam int PT_W       = 13;
    localparam int PEAK_SAT   = 4096;

    // datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int WORD_W     = 32;
    localparam int COEF_W     = 20;
    localparam int PROD_W     = COEF_W + WORD_W;
    localparam int ACC_W      = 56;
    localparam int FRAC_W     = 16;
    localparam int SH_W       = ACC_W - FRAC_W;

    // configuration register widths and reset values
    localparam int NUM_W      = 3 * COEF_W;
    localparam int DEN_W      = 2 * COEF_W;
    localparam int THR_W      = 31;
    localparam int DECAY_W    = 16;
    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(6480);
    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(50);

    // apb port
    localparam int ADDR_W     = 6;
    localparam int APB_DATA_W = 64;

    // stream payload widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    // register map, index is byte address / 8
    typedef enum logic [2:0] {
        REG_S1_NUM = 3'd0,
        REG_S1_DEN = 3'd1,
        REG_S2_NUM = 3'd2,
        REG_S2_DEN = 3'd3,
        REG_THRESH = 3'd4,
        REG_DECAY  = 3'd5
    } reg_idx_t;

    // microcode fields
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_CLR
    } acc_op_t;

    typedef enum logic [2:0] {
        C_A1,
        C_A2,
        C_B0,
        C_B1,
        C_B2
    } coef_sel_t;

    typedef enum logic [1:0] {
        OP_W1,
        OP_W2,
        OP_W
    } opnd_sel_t;

    typedef struct packed {
        acc_op_t   acc_op;
        logic      mul_en;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        logic      sat_w;
        logic      sat_y;
        logic      loop_back;
        logic      finish;
    } ucw_t;

    localparam int STEP_W   = 4;
    localparam int UC_LAST  = 9;

    localparam ucw_t UCW_NOP = '{
        acc_op: ACC_NONE, mul_en: 1'b0, coef_sel: C_A1, opnd_sel: OP_W1,
        sat_w: 1'b0, sat_y: 1'b0, loop_back: 1'b0, finish: 1'b0
    };

    // one biquad program, run once per stage, then the envelope step
    function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
        ucw_t w;
        w = UCW_NOP;
        unique case (step)
            4'd0:
            begin
                w.acc_op = ACC_LOAD;
                w.mul_en = 1'b1; w.coef_sel = C_A1; w.opnd_sel = OP_W1;
            end
            4'd1:
            begin
                w.acc_op = ACC_SUB;
                w.mul_en = 1'b1; w.coef_sel = C_A2; w.opnd_sel = OP_W2;
            end
            4'd2:
            begin
                w.acc_op = ACC_SUB;
            end
            4'd3:
            begin
                w.sat_w  = 1'b1;
                w.acc_op = ACC_CLR;
            end
            4'd4:
            begin
                w.mul_en = 1'b1; w.coef_sel = C_B0; w.opnd_sel = OP_W;
            end
            4'd5:
            begin
                w.acc_op = ACC_ADD;
                w.mul_en = 1'b1; w.coef_sel = C_B1; w.opnd_sel = OP_W1;
            end
            4'd6:
            begin
                w.acc_op = ACC_ADD;
                w.mul_en = 1'b1; w.coef_sel = C_B2; w.opnd_sel = OP_W2;
            end
            4'd7:
            begin
                w.acc_op = ACC_ADD;
            end
            4'd8:
            begin
                w.sat_y     = 1'b1;
                w.loop_back = 1'b1;
            end
            4'd9:
            begin
                w.finish = 1'b1;
            end
            default:
            begin
                w = UCW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ecg_envelope_peak_interval.sv
// ----------------------------------------------------------------------------
// ecg_envelope_peak_interval: two biquads, envelope and s1/s2 peak intervals
// one sample at a time: s_tready is low while busy, since the single shared 20x32
// multiplier runs the 9-step biquad program twice, plus one envelope step that
// waits while the output register is stalled
// reset: rst_n clears all control state and the filter delays at once, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecg_envelope_peak_interval
    import ecgepi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // apb configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    // sample input: [15:0] sample_in
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,

    // result output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] envelope_out, [43:32] s1_interval, [55:44] s12_interval,
    // [67:56] position, [71:68] zero
    output logic      [OUT_DATA_W-1:0] m_tdata,
    // [0] peak_found, [1] peak_parity
    output logic      [OUT_USER_W-1:0] m_tuser
);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [NUM_W-1:0]   s1_num_reg, s2_num_reg;
    logic [DEN_W-1:0]   s1_den_reg, s2_den_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [DECAY_W-1:0] decay_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_num_reg <= '0;
            s1_den_reg <= '0;
            s2_num_reg <= '0;
            s2_den_reg <= '0;
            thr_reg    <= THR_RESET;
            decay_reg  <= DECAY_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_S1_NUM: s1_num_reg <= pwdata[NUM_W-1:0];
                REG_S1_DEN: s1_den_reg <= pwdata[DEN_W-1:0];
                REG_S2_NUM: s2_num_reg <= pwdata[NUM_W-1:0];
                REG_S2_DEN: s2_den_reg <= pwdata[DEN_W-1:0];
                REG_THRESH: thr_reg    <= pwdata[THR_W-1:0];
                REG_DECAY:  decay_reg  <= pwdata[DECAY_W-1:0];
                default:    ;  // addresses past the map are ignored
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_S1_NUM: prdata = APB_DATA_W'(s1_num_reg);
            REG_S1_DEN: prdata = APB_DATA_W'(s1_den_reg);
            REG_S2_NUM: prdata = APB_DATA_W'(s2_num_reg);
            REG_S2_DEN: prdata = APB_DATA_W'(s2_den_reg);
            REG_THRESH: prdata = APB_DATA_W'(thr_reg);
            REG_DECAY:  prdata = APB_DATA_W'(decay_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer: step counter into the microcode rom, stage bit picks biquad
    // ------------------------------------------------------------------------
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              stage_reg, stage_next;
    ucw_t              ucw;
    logic              in_beat;
    logic              out_stall;
    logic              env_go;

    assign s_tready  = !busy_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign ucw       = ucode(step_reg);
    assign out_stall = m_tvalid && !m_tready;
    // envelope step commits only when the output register can take the result
    assign env_go    = busy_reg && ucw.finish && !out_stall;

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        stage_next = stage_reg;
        priority if (!busy_reg)
        begin
            busy_next = in_beat;
        end
        else if (ucw.loop_back && !stage_reg)
        begin
            // stage one done, rerun the biquad program for stage two
            step_next  = '0;
            stage_next = 1'b1;
        end
        else if (ucw.finish)
        begin
            if (env_go)
            begin
                step_next  = '0;
                stage_next = 1'b0;
                busy_next  = 1'b0;
            end
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            stage_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            stage_reg <= stage_next;
        end
    end

    // ------------------------------------------------------------------------
    // biquad datapath: shared multiplier, product register, accumulator
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [WORD_W-1:0]   w_reg;
    logic signed [WORD_W-1:0]   y_reg;
    logic signed [PROD_W-1:0]   mul_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;

    logic signed [WORD_W-1:0]   s1_w1_reg, s1_w2_reg, s2_w1_reg, s2_w2_reg;
    logic signed [WORD_W-1:0]   s1_w1_next, s1_w2_next, s2_w1_next, s2_w2_next;

    logic [NUM_W-1:0]           num_sel;
    logic [DEN_W-1:0]           den_sel;
    logic signed [COEF_W-1:0]   coef_v;
    logic signed [WORD_W-1:0]   opnd_v;
    logic signed [WORD_W-1:0]   w1_v, w2_v;
    logic signed [WORD_W-1:0]   x_v;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [SH_W-1:0]     acc_sh;
    logic signed [WORD_W-1:0]   acc_sat;

    // clamp a floor-shifted accumulator to 32 bits
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SH_W-1:0] v);
        logic [SH_W-WORD_W:0] top;
        top = v[SH_W-1:WORD_W-1];
        if (top == '0 || top == '1)
            return v[WORD_W-1:0];
        else if (v[SH_W-1])
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    assign num_sel = stage_reg ? s2_num_reg : s1_num_reg;
    assign den_sel = stage_reg ? s2_den_reg : s1_den_reg;
    assign w1_v    = stage_reg ? s2_w1_reg  : s1_w1_reg;
    assign w2_v    = stage_reg ? s2_w2_reg  : s1_w2_reg;
    // stage two takes stage one's output
    assign x_v     = stage_reg ? y_reg
                               : {{(WORD_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};

    always_comb
    begin
        unique case (ucw.coef_sel)
            C_A1:    coef_v = den_sel[COEF_W-1:0];
            C_A2:    coef_v = den_sel[2*COEF_W-1:COEF_W];
            C_B0:    coef_v = num_sel[COEF_W-1:0];
            C_B1:    coef_v = num_sel[2*COEF_W-1:COEF_W];
            C_B2:    coef_v = num_sel[3*COEF_W-1:2*COEF_W];
            default: coef_v = '0;
        endcase
        unique case (ucw.opnd_sel)
            OP_W1:   opnd_v = w1_v;
            OP_W2:   opnd_v = w2_v;
            OP_W:    opnd_v = w_reg;
            default: opnd_v = '0;
        endcase
    end

    assign prod     = coef_v * opnd_v;
    assign prod_ext = {{(ACC_W-PROD_W){mul_reg[PROD_W-1]}}, mul_reg};
    // arithmetic shift is the floor of the division by 2^16
    assign acc_sh   = acc_reg[ACC_W-1:FRAC_W];
    assign acc_sat  = sat32(acc_sh);

    always_comb
    begin
        unique case (ucw.acc_op)
            ACC_NONE: acc_next = acc_reg;
            ACC_LOAD: acc_next = {{(ACC_W-WORD_W-FRAC_W){x_v[WORD_W-1]}}, x_v,
                                  {FRAC_W{1'b0}}};
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            ACC_CLR:  acc_next = '0;
            default:  acc_next = acc_reg;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        if (busy_reg && ucw.mul_en)
            mul_reg <= prod;
        if (busy_reg)
            acc_reg <= acc_next;
        if (busy_reg && ucw.sat_w)
            w_reg <= acc_sat;
        if (busy_reg && ucw.sat_y)
            y_reg <= acc_sat;
    end

    // ------------------------------------------------------------------------
    // envelope, peak detection and intervals
    // ------------------------------------------------------------------------
    logic signed [WORD_W-1:0] prev_env_reg, prev_env_next;
    logic [CNT_W-1:0]         rec_pos_reg, rec_pos_next;
    logic                     above_reg, above_next;
    logic [PT_W-1:0]          pt_reg, pt_next;
    logic [IDX_W-1:0]         latest_reg, latest_next;
    logic [IDX_W-1:0]         earlier_reg, earlier_next;
    logic [IDX_W-1:0]         pref_reg, pref_next;
    logic [IDX_W-1:0]         s1_int_reg, s1_int_next;
    logic [IDX_W-1:0]         s12_int_reg, s12_int_next;

    logic [IDX_W-1:0]         pos;
    logic signed [WORD_W-1:0] rect;
    logic signed [WORD_W:0]   decayed;
    logic signed [WORD_W-1:0] env;
    logic                     found;
    logic                     rec_end;

    assign pos     = rec_pos_reg[IDX_W-1:0];
    assign rec_end = (rec_pos_reg == CNT_W'(RECORD_LEN - 1));
    assign decayed = {prev_env_reg[WORD_W-1], prev_env_reg}
                     - $signed({{(WORD_W+1-DECAY_W){1'b0}}, decay_reg});

    always_comb
    begin
        // rectify, the most negative value clamps to the largest positive
        if (y_reg == {1'b1, {(WORD_W-1){1'b0}}})
            rect = {1'b0, {(WORD_W-1){1'b1}}};
        else if (y_reg[WORD_W-1])
            rect = -y_reg;
        else
            rect = y_reg;

        // falling envelope decays from the previous value, not at record start
        env = rect;
        if (rec_pos_reg != '0 && rect < prev_env_reg)
        begin
            if (decayed[WORD_W] && !decayed[WORD_W-1])
                env = {1'b1, {(WORD_W-1){1'b0}}};
            else
                env = decayed[WORD_W-1:0];
        end

        prev_env_next = env;
        above_next    = above_reg;
        pt_next       = pt_reg;
        latest_next   = latest_reg;
        earlier_next  = earlier_reg;
        pref_next     = pref_reg;
        s1_int_next   = s1_int_reg;
        s12_int_next  = s12_int_reg;
        found         = 1'b0;

        // rising crossing of the threshold starts a peak
        if ($signed({env[WORD_W-1], env}) >= $signed({2'b00, thr_reg}))
        begin
            if (!above_reg)
            begin
                if (pt_reg != PT_W'(PEAK_SAT))
                    pt_next = pt_reg + PT_W'(1);
                earlier_next = latest_reg;
                latest_next  = pos;
                above_next   = 1'b1;
                found        = 1'b1;
            end
        end
        else
        begin
            above_next = 1'b0;
        end

        // odd count: s1 to s1, even count: s1 to s2
        if (pt_next[0] && pt_next > PT_W'(2))
        begin
            s1_int_next = latest_next - pref_reg;
        end
        else if (!pt_next[0] && pt_next > PT_W'(1))
        begin
            pref_next    = earlier_next;
            s12_int_next = latest_next - earlier_next;
        end

        rec_pos_next = rec_end ? '0 : rec_pos_reg + CNT_W'(1);
    end

    // filter delays: shift at the end of each stage, clear at record wrap
    always_comb
    begin
        s1_w1_next = s1_w1_reg;
        s1_w2_next = s1_w2_reg;
        s2_w1_next = s2_w1_reg;
        s2_w2_next = s2_w2_reg;
        if (busy_reg && ucw.sat_y)
        begin
            if (stage_reg)
            begin
                s2_w2_next = s2_w1_reg;
                s2_w1_next = w_reg;
            end
            else
            begin
                s1_w2_next = s1_w1_reg;
                s1_w1_next = w_reg;
            end
        end
        if (env_go && rec_end)
        begin
            s1_w1_next = '0;
            s1_w2_next = '0;
            s2_w1_next = '0;
            s2_w2_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_w1_reg    <= '0;
            s1_w2_reg    <= '0;
            s2_w1_reg    <= '0;
            s2_w2_reg    <= '0;
            prev_env_reg <= '0;
            rec_pos_reg  <= '0;
            above_reg    <= 1'b0;
            pt_reg       <= '0;
            latest_reg   <= '0;
            earlier_reg  <= '0;
            pref_reg     <= '0;
            s1_int_reg   <= '0;
            s12_int_reg  <= '0;
        end
        else
        begin
            s1_w1_reg <= s1_w1_next;
            s1_w2_reg <= s1_w2_next;
            s2_w1_reg <= s2_w1_next;
            s2_w2_reg <= s2_w2_next;
            if (env_go)
            begin
                prev_env_reg <= prev_env_next;
                rec_pos_reg  <= rec_pos_next;
                above_reg    <= above_next;
                s1_int_reg   <= s1_int_next;
                s12_int_reg  <= s12_int_next;
                // peak state clears at record wrap, after the outputs are taken
                pt_reg       <= rec_end ? '0 : pt_next;
                latest_reg   <= rec_end ? '0 : latest_next;
                earlier_reg  <= rec_end ? '0 : earlier_next;
                pref_reg     <= rec_end ? '0 : pref_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output register, parts the sequencer from the downstream beat
    // ------------------------------------------------------------------------
    logic m_tvalid_reg, m_tvalid_next;

    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (env_go)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (env_go)
        begin
            m_tdata <= {{(OUT_DATA_W-WORD_W-3*IDX_W){1'b0}}, pos, s12_int_next,
                        s1_int_next, env};
            m_tuser <= {pt_next[0], found};
        end
    end

`ifndef ASSERT_OFF
    // an idle sequencer sits at the program start for stage one
    a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_reg == '0 && !stage_reg))
        else $error("sequencer idle away from program start");

    // the step counter never runs past the last microcode step
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(UC_LAST))
        else $error("step counter past end of program");

    // a new result is only loaded by the envelope step of a running sample
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(env_go))
        else $error("result appeared without an envelope step");

    // the peak count saturates
    a_peak_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pt_reg <= PT_W'(PEAK_SAT))
        else $error("peak count above saturation");
`endif

endmodule

`default_nettype wire
